// ===== design/dual_quat_point_transform_defines.svh =====
// Assertion macros shared by the dual quaternion point transform RTL.
// Expects aclk and aresetn in scope of the including module.
`ifndef DUAL_QUAT_POINT_TRANSFORM_DEFINES_SVH
`define DUAL_QUAT_POINT_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DQPT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dqpt: implication check failed");

// Next-cycle implication, disabled while reset is held.
`define DQPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dqpt: next-cycle check failed");

`endif

// ===== design/dqpt_pkg.sv =====
// Package for the dual quaternion point transform: widths, rounding constants
// and the payload structs passed between pipeline modules. No dependencies.
`default_nettype none

package dqpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ROT_W     = 18;
    localparam int COORD_W   = 32;

    // rotation products and the matrix sums built from them
    localparam int RPROD_W   = 2 * ROT_W;
    localparam int MAT_SUM_W = RPROD_W + 2;
    localparam int MAT_W     = MAT_SUM_W - FRAC_BITS + 1;

    // dual * rotation products and the translation sums
    localparam int DPROD_W   = COORD_W + ROT_W;
    localparam int TRANS_W   = DPROD_W + 3;

    // point * matrix products and the final accumulation
    localparam int PPROD_W   = COORD_W + MAT_W;
    localparam int ACC_W     = ((TRANS_W > PPROD_W) ? TRANS_W : PPROD_W) + 3;
    localparam int RND_W     = ACC_W - FRAC_BITS;

    localparam logic signed [MAT_SUM_W-1:0] MAT_HALF = MAT_SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]     ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [MAT_W-1:0]   mat_t;
    typedef logic signed [TRANS_W-1:0] trans_t;

    // one accepted input item
    typedef struct packed {
        rot_t   w;
        rot_t   x;
        rot_t   y;
        rot_t   z;
        coord_t dw;
        coord_t dx;
        coord_t dy;
        coord_t dz;
        coord_t px;
        coord_t py;
        coord_t pz;
    } dq_item_t;

    // rounded rotation matrix, exact translation and the point
    typedef struct packed {
        mat_t   m00;
        mat_t   m01;
        mat_t   m02;
        mat_t   m10;
        mat_t   m11;
        mat_t   m12;
        mat_t   m20;
        mat_t   m21;
        mat_t   m22;
        trans_t tx;
        trans_t ty;
        trans_t tz;
        coord_t px;
        coord_t py;
        coord_t pz;
    } xform_t;

    // one result item
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   sat;
    } result_t;

endpackage

`default_nettype wire

// ===== design/dqpt_matrix.sv =====
// Front half of the transform pipeline: rotation and dual products, then the
// rounded rotation matrix and exact translation. Depends on dqpt_pkg.
`default_nettype none

module dqpt_matrix import dqpt_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dq_item_t in_item,
    output logic          out_valid,
    input  wire logic     out_ready,
    output xform_t        out_xf
);

    // stage A: products
    logic a_valid_reg, a_valid_next, a_ready;
    // rotation products: ww xx yy zz xy wz wy xz yz wx
    logic signed [RPROD_W-1:0] rp_reg [10];
    logic signed [RPROD_W-1:0] rp_next [10];
    // dual products: dx*w dw*x dz*y dy*z | dy*w dz*x dw*y dx*z | dz*w dy*x dx*y dw*z
    logic signed [DPROD_W-1:0] dp_reg [12];
    logic signed [DPROD_W-1:0] dp_next [12];
    coord_t a_px_reg, a_py_reg, a_pz_reg;

    // stage B: matrix and translation
    logic   b_valid_reg, b_valid_next, b_ready;
    xform_t b_xf_reg, b_xf_next;

    function automatic mat_t round_mat(input logic signed [MAT_SUM_W-1:0] d);
        logic signed [MAT_SUM_W-1:0] r;
        r = (d + MAT_HALF) >>> FRAC_BITS;
        return r[MAT_W-1:0];
    endfunction

    function automatic logic signed [MAT_SUM_W-1:0] ext_r(
        input logic signed [RPROD_W-1:0] v);
        return MAT_SUM_W'(v);
    endfunction

    function automatic trans_t ext_d(input logic signed [DPROD_W-1:0] v);
        return TRANS_W'(v);
    endfunction

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        a_valid_next = a_ready ? in_valid : a_valid_reg;
        rp_next[0] = RPROD_W'(in_item.w) * RPROD_W'(in_item.w);
        rp_next[1] = RPROD_W'(in_item.x) * RPROD_W'(in_item.x);
        rp_next[2] = RPROD_W'(in_item.y) * RPROD_W'(in_item.y);
        rp_next[3] = RPROD_W'(in_item.z) * RPROD_W'(in_item.z);
        rp_next[4] = RPROD_W'(in_item.x) * RPROD_W'(in_item.y);
        rp_next[5] = RPROD_W'(in_item.w) * RPROD_W'(in_item.z);
        rp_next[6] = RPROD_W'(in_item.w) * RPROD_W'(in_item.y);
        rp_next[7] = RPROD_W'(in_item.x) * RPROD_W'(in_item.z);
        rp_next[8] = RPROD_W'(in_item.y) * RPROD_W'(in_item.z);
        rp_next[9] = RPROD_W'(in_item.w) * RPROD_W'(in_item.x);
        dp_next[0]  = DPROD_W'(in_item.dx) * DPROD_W'(in_item.w);
        dp_next[1]  = DPROD_W'(in_item.dw) * DPROD_W'(in_item.x);
        dp_next[2]  = DPROD_W'(in_item.dz) * DPROD_W'(in_item.y);
        dp_next[3]  = DPROD_W'(in_item.dy) * DPROD_W'(in_item.z);
        dp_next[4]  = DPROD_W'(in_item.dy) * DPROD_W'(in_item.w);
        dp_next[5]  = DPROD_W'(in_item.dz) * DPROD_W'(in_item.x);
        dp_next[6]  = DPROD_W'(in_item.dw) * DPROD_W'(in_item.y);
        dp_next[7]  = DPROD_W'(in_item.dx) * DPROD_W'(in_item.z);
        dp_next[8]  = DPROD_W'(in_item.dz) * DPROD_W'(in_item.w);
        dp_next[9]  = DPROD_W'(in_item.dy) * DPROD_W'(in_item.x);
        dp_next[10] = DPROD_W'(in_item.dx) * DPROD_W'(in_item.y);
        dp_next[11] = DPROD_W'(in_item.dw) * DPROD_W'(in_item.z);
    end

    always_comb begin
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
        b_xf_next.m00 = round_mat(ext_r(rp_reg[0]) + ext_r(rp_reg[1])
                                  - ext_r(rp_reg[2]) - ext_r(rp_reg[3]));
        b_xf_next.m01 = round_mat((ext_r(rp_reg[4]) - ext_r(rp_reg[5])) <<< 1);
        b_xf_next.m02 = round_mat((ext_r(rp_reg[6]) + ext_r(rp_reg[7])) <<< 1);
        b_xf_next.m10 = round_mat((ext_r(rp_reg[4]) + ext_r(rp_reg[5])) <<< 1);
        b_xf_next.m11 = round_mat(ext_r(rp_reg[0]) - ext_r(rp_reg[1])
                                  + ext_r(rp_reg[2]) - ext_r(rp_reg[3]));
        b_xf_next.m12 = round_mat((ext_r(rp_reg[8]) - ext_r(rp_reg[9])) <<< 1);
        b_xf_next.m20 = round_mat((ext_r(rp_reg[7]) - ext_r(rp_reg[6])) <<< 1);
        b_xf_next.m21 = round_mat((ext_r(rp_reg[9]) + ext_r(rp_reg[8])) <<< 1);
        b_xf_next.m22 = round_mat(ext_r(rp_reg[0]) - ext_r(rp_reg[1])
                                  - ext_r(rp_reg[2]) + ext_r(rp_reg[3]));
        b_xf_next.tx = (ext_d(dp_reg[1]) - ext_d(dp_reg[0])
                        - ext_d(dp_reg[2]) + ext_d(dp_reg[3])) <<< 1;
        b_xf_next.ty = (ext_d(dp_reg[5]) - ext_d(dp_reg[4])
                        + ext_d(dp_reg[6]) - ext_d(dp_reg[7])) <<< 1;
        b_xf_next.tz = (ext_d(dp_reg[10]) - ext_d(dp_reg[8])
                        - ext_d(dp_reg[9]) + ext_d(dp_reg[11])) <<< 1;
        b_xf_next.px = a_px_reg;
        b_xf_next.py = a_py_reg;
        b_xf_next.pz = a_pz_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            rp_reg   <= rp_next;
            dp_reg   <= dp_next;
            a_px_reg <= in_item.px;
            a_py_reg <= in_item.py;
            a_pz_reg <= in_item.pz;
        end
        if (b_ready && a_valid_reg) begin
            b_xf_reg <= b_xf_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_xf    = b_xf_reg;

endmodule

`default_nettype wire

// ===== design/dqpt_apply.sv =====
// Back half of the transform pipeline: point times matrix, sum with the
// translation, round, clip and hold the result. Depends on dqpt_pkg.
`default_nettype none

module dqpt_apply import dqpt_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire xform_t in_xf,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     out_res
);

    // stage C: nine point products, row major
    logic   c_valid_reg, c_valid_next, c_ready;
    logic signed [PPROD_W-1:0] pp_reg [9];
    logic signed [PPROD_W-1:0] pp_next [9];
    trans_t c_tx_reg, c_ty_reg, c_tz_reg;

    // stage D: rounded sums
    logic d_valid_reg, d_valid_next, d_ready;
    logic signed [RND_W-1:0] rnd_reg [3];
    logic signed [RND_W-1:0] rnd_next [3];

    // stage E: clipped result
    logic    e_valid_reg, e_valid_next, e_ready;
    result_t e_res_reg, e_res_next;

    localparam logic signed [RND_W-1:0] CLIP_MAX = RND_W'(COORD_MAX);
    localparam logic signed [RND_W-1:0] CLIP_MIN = RND_W'(COORD_MIN);

    function automatic logic signed [PPROD_W-1:0] mul_pm(input coord_t p, input mat_t m);
        return PPROD_W'(p) * PPROD_W'(m);
    endfunction

    function automatic logic signed [RND_W-1:0] sum_round(
        input trans_t t,
        input logic signed [PPROD_W-1:0] a,
        input logic signed [PPROD_W-1:0] b,
        input logic signed [PPROD_W-1:0] c);
        logic signed [ACC_W-1:0] acc;
        acc = ACC_W'(t) + ACC_W'(a) + ACC_W'(b) + ACC_W'(c) + ACC_HALF;
        acc = acc >>> FRAC_BITS;
        return acc[RND_W-1:0];
    endfunction

    // {clipped flag, coordinate}
    function automatic logic [COORD_W:0] clip(input logic signed [RND_W-1:0] v);
        logic [COORD_W:0] r;
        if (v > CLIP_MAX) begin
            r = {1'b1, COORD_MAX};
        end else if (v < CLIP_MIN) begin
            r = {1'b1, COORD_MIN};
        end else begin
            r = {1'b0, v[COORD_W-1:0]};
        end
        return r;
    endfunction

    assign e_ready  = !e_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_comb begin
        logic [COORD_W:0] cx, cy, cz;
        c_valid_next = c_ready ? in_valid : c_valid_reg;
        d_valid_next = d_ready ? c_valid_reg : d_valid_reg;
        e_valid_next = e_ready ? d_valid_reg : e_valid_reg;

        pp_next[0] = mul_pm(in_xf.px, in_xf.m00);
        pp_next[1] = mul_pm(in_xf.py, in_xf.m01);
        pp_next[2] = mul_pm(in_xf.pz, in_xf.m02);
        pp_next[3] = mul_pm(in_xf.px, in_xf.m10);
        pp_next[4] = mul_pm(in_xf.py, in_xf.m11);
        pp_next[5] = mul_pm(in_xf.pz, in_xf.m12);
        pp_next[6] = mul_pm(in_xf.px, in_xf.m20);
        pp_next[7] = mul_pm(in_xf.py, in_xf.m21);
        pp_next[8] = mul_pm(in_xf.pz, in_xf.m22);

        rnd_next[0] = sum_round(c_tx_reg, pp_reg[0], pp_reg[1], pp_reg[2]);
        rnd_next[1] = sum_round(c_ty_reg, pp_reg[3], pp_reg[4], pp_reg[5]);
        rnd_next[2] = sum_round(c_tz_reg, pp_reg[6], pp_reg[7], pp_reg[8]);

        cx = clip(rnd_reg[0]);
        cy = clip(rnd_reg[1]);
        cz = clip(rnd_reg[2]);
        e_res_next.x   = cx[COORD_W-1:0];
        e_res_next.y   = cy[COORD_W-1:0];
        e_res_next.z   = cz[COORD_W-1:0];
        e_res_next.sat = cx[COORD_W] | cy[COORD_W] | cz[COORD_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
            e_valid_reg <= e_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            pp_reg   <= pp_next;
            c_tx_reg <= in_xf.tx;
            c_ty_reg <= in_xf.ty;
            c_tz_reg <= in_xf.tz;
        end
        if (d_ready && c_valid_reg) begin
            rnd_reg <= rnd_next;
        end
        if (e_ready && d_valid_reg) begin
            e_res_reg <= e_res_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_res   = e_res_reg;

endmodule

`default_nettype wire

// ===== design/dual_quat_point_transform.sv =====
// Dual quaternion rigid point transform, stream in and stream out.
// Depends on dqpt_pkg, dqpt_matrix, dqpt_apply and the assertion macro header.
//
// Each input transfer carries one bone's dual quaternion (rotation part in
// signed Q1.16, dual part in signed Q15.16) and one vertex in signed Q15.16;
// each produces exactly one output transfer with the transformed vertex,
// saturated to the signed 32-bit range, and a flag in tuser that is set when
// any coordinate was clipped. The block takes one vertex per clock while the
// sink keeps up. Output valid rises once the item has passed the five
// register stages: rotation and dual products, matrix rounding and
// translation sums, point products, final sum and rounding, clipping into the
// output register. Every stage has its own valid bit and a ready that opens
// when the stage is empty or moving on, so bubbles squeeze out under back
// pressure and nothing is dropped or repeated. No normalization of the
// rotation is done; a non-unit quaternion is applied as it stands. There are
// no configuration registers and no state between vertices.
`default_nettype none
`include "dual_quat_point_transform_defines.svh"

module dual_quat_point_transform import dqpt_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // rot_w, rot_x, rot_y, rot_z (18 each), dual_w, dual_x, dual_y, dual_z,
    // pos_x, pos_y, pos_z (32 each), from bit 0 up
    input  wire logic [295:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_x, out_y, out_z (32 each), from bit 0 up
    output logic [95:0]       m_axis_tdata,
    // saturated
    output logic              m_axis_tuser
);

    dq_item_t in_item;
    xform_t   mat_xf;
    logic     mat_valid, mat_ready;
    result_t  res;
    logic     res_on_limit;

    // unpack the input transfer
    assign in_item.w  = s_axis_tdata[17:0];
    assign in_item.x  = s_axis_tdata[35:18];
    assign in_item.y  = s_axis_tdata[53:36];
    assign in_item.z  = s_axis_tdata[71:54];
    assign in_item.dw = s_axis_tdata[103:72];
    assign in_item.dx = s_axis_tdata[135:104];
    assign in_item.dy = s_axis_tdata[167:136];
    assign in_item.dz = s_axis_tdata[199:168];
    assign in_item.px = s_axis_tdata[231:200];
    assign in_item.py = s_axis_tdata[263:232];
    assign in_item.pz = s_axis_tdata[295:264];

    // products, then rounded matrix and translation
    dqpt_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_xf    (mat_xf)
    );

    // apply to the point, round, clip and hold for the output transfer
    dqpt_apply u_apply (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_xf     (mat_xf),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.z, res.y, res.x};
    assign m_axis_tuser = res.sat;

    // some output coordinate sits on a range limit
    assign res_on_limit = (res.x == COORD_MAX) || (res.x == COORD_MIN) ||
                          (res.y == COORD_MAX) || (res.y == COORD_MIN) ||
                          (res.z == COORD_MAX) || (res.z == COORD_MIN);

    // the flag is only raised when some coordinate sits on a range limit
    `DQPT_ASSERT_IMPL(a_sat_on_limit, m_axis_tvalid && m_axis_tuser, res_on_limit)
    // the input side only stalls when every stage is full and the sink stalls
    `DQPT_ASSERT_IMPL(a_stall_only_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    // hold the mid-pipeline item while the back half cannot take it
    `DQPT_ASSERT_NEXT(a_mid_hold, mat_valid && !mat_ready, mat_valid && $stable(mat_xf))

endmodule

`default_nettype wire

// ===== tb/dual_quat_point_transform_tb.sv =====
// Self-checking testbench for dual_quat_point_transform: stream driver, result
// monitor and a bit-exact transform predictor. Depends on dqpt_pkg and the RTL.
`timescale 1ns / 100ps

module dual_quat_point_transform_tb;
    import dqpt_pkg::*;

    localparam rot_t   ROT_MAX  = {1'b0, {(ROT_W-1){1'b1}}};
    localparam rot_t   ROT_MIN  = {1'b1, {(ROT_W-1){1'b0}}};
    localparam rot_t   ROT_ONE  = rot_t'(1) << FRAC_BITS;
    localparam longint LIMIT_HI = longint'(COORD_MAX);
    localparam longint LIMIT_LO = longint'(COORD_MIN);
    localparam int     TAIL_CYCLES = 20;   // five stages plus margin

    // flavors of random vertex traffic
    typedef enum int {
        MIX_RAW,      // every bit random
        MIX_RIGID,    // unit rotation, consistent dual part, moderate point
        MIX_EDGE,     // fields mostly drawn from extremes and special values
        MIX_SMALL     // small values, exercises rounding
    } vertex_mix_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [295:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;

    dq_item_t pending_vertices[$];   // waiting to be driven
    result_t  expected_points[$];    // predicted, waiting for the output side
    dq_item_t seen_vertex;
    result_t  oldest_point;
    logic     s_taken = 1'b0;        // input transfer at the last rising edge
    int       src_idle_pct = 0;
    int       snk_stall_pct = 0;
    int       errors = 0;

    dual_quat_point_transform DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half up: floor((v + 2^(F-1)) / 2^F), arithmetic shift is a floor.
    function automatic longint round_frac(longint v);
        return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic coord_t clip_coord(longint v);
        if (v > LIMIT_HI) begin
            return COORD_MAX;
        end
        if (v < LIMIT_LO) begin
            return COORD_MIN;
        end
        return coord_t'(v);
    endfunction

    // Rotate the point with the rounded quadratic matrix, add the exact
    // translation 2*(r * conj(d)), round once and clip each coordinate.
    function automatic result_t transform_vertex(dq_item_t v);
        longint w, x, y, z, dw, dx, dy, dz, px, py, pz;
        longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
        longint tx, ty, tz, ax, ay, az;
        result_t res;
        w  = $signed(v.w);   x  = $signed(v.x);
        y  = $signed(v.y);   z  = $signed(v.z);
        dw = $signed(v.dw);  dx = $signed(v.dx);
        dy = $signed(v.dy);  dz = $signed(v.dz);
        px = $signed(v.px);  py = $signed(v.py);  pz = $signed(v.pz);

        r00 = round_frac(w * w + x * x - y * y - z * z);
        r01 = round_frac(2 * (x * y - w * z));
        r02 = round_frac(2 * (w * y + x * z));
        r10 = round_frac(2 * (x * y + w * z));
        r11 = round_frac(w * w - x * x + y * y - z * z);
        r12 = round_frac(2 * (y * z - w * x));
        r20 = round_frac(2 * (x * z - w * y));
        r21 = round_frac(2 * (w * x + y * z));
        r22 = round_frac(w * w - x * x - y * y + z * z);

        tx = 2 * (-dx * w + dw * x - dz * y + dy * z);
        ty = 2 * (-dy * w + dz * x + dw * y - dx * z);
        tz = 2 * (-dz * w - dy * x + dx * y + dw * z);

        ax = round_frac(tx + px * r00 + py * r01 + pz * r02);
        ay = round_frac(ty + px * r10 + py * r11 + pz * r12);
        az = round_frac(tz + px * r20 + py * r21 + pz * r22);

        res.x   = clip_coord(ax);
        res.y   = clip_coord(ay);
        res.z   = clip_coord(az);
        res.sat = (ax > LIMIT_HI) || (ax < LIMIT_LO) || (ay > LIMIT_HI) ||
                  (ay < LIMIT_LO) || (az > LIMIT_HI) || (az < LIMIT_LO);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            // Load a new vertex only once the current one has transferred;
            // hold tdata and tvalid steady while the block stalls.
            if (!s_axis_tvalid || s_taken) begin
                if (pending_vertices.size() > 0 &&
                    $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tdata <= {pending_vertices[0].pz, pending_vertices[0].py,
                                     pending_vertices[0].px, pending_vertices[0].dz,
                                     pending_vertices[0].dy, pending_vertices[0].dx,
                                     pending_vertices[0].dw, pending_vertices[0].z,
                                     pending_vertices[0].y,  pending_vertices[0].x,
                                     pending_vertices[0].w};
                    void'(pending_vertices.pop_front());
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            // Stall the output side at random.
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        s_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn) begin
            // Check the output transfer against the oldest prediction.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_points.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected output transfer tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    oldest_point = expected_points.pop_front();
                    if (m_axis_tdata[31:0] !== oldest_point.x) begin
                        errors++;
                        $display("%0t: out_x expected %h actual %h",
                                 $time, oldest_point.x, m_axis_tdata[31:0]);
                    end
                    if (m_axis_tdata[63:32] !== oldest_point.y) begin
                        errors++;
                        $display("%0t: out_y expected %h actual %h",
                                 $time, oldest_point.y, m_axis_tdata[63:32]);
                    end
                    if (m_axis_tdata[95:64] !== oldest_point.z) begin
                        errors++;
                        $display("%0t: out_z expected %h actual %h",
                                 $time, oldest_point.z, m_axis_tdata[95:64]);
                    end
                    if (m_axis_tuser !== oldest_point.sat) begin
                        errors++;
                        $display("%0t: saturated expected %b actual %b",
                                 $time, oldest_point.sat, m_axis_tuser);
                    end
                end
            end
            // Predict the result of every accepted input transfer.
            if (s_axis_tvalid && s_axis_tready) begin
                seen_vertex.w  = s_axis_tdata[17:0];
                seen_vertex.x  = s_axis_tdata[35:18];
                seen_vertex.y  = s_axis_tdata[53:36];
                seen_vertex.z  = s_axis_tdata[71:54];
                seen_vertex.dw = s_axis_tdata[103:72];
                seen_vertex.dx = s_axis_tdata[135:104];
                seen_vertex.dy = s_axis_tdata[167:136];
                seen_vertex.dz = s_axis_tdata[199:168];
                seen_vertex.px = s_axis_tdata[231:200];
                seen_vertex.py = s_axis_tdata[263:232];
                seen_vertex.pz = s_axis_tdata[295:264];
                expected_points.push_back(transform_vertex(seen_vertex));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_vertex(rot_t w, rot_t x, rot_t y, rot_t z,
                              coord_t dw, coord_t dx, coord_t dy, coord_t dz,
                              coord_t px, coord_t py, coord_t pz);
        dq_item_t v;
        v = '{w: w, x: x, y: y, z: z, dw: dw, dx: dx, dy: dy, dz: dz,
              px: px, py: py, pz: pz};
        pending_vertices.push_back(v);
    endtask

    function automatic rot_t pick_rot();
        case ($urandom_range(7))
            0: return ROT_MAX;
            1: return ROT_MIN;
            2: return '0;
            3: return rot_t'(1);
            4: return rot_t'(-1);
            5: return ROT_ONE;
            6: return -ROT_ONE;
            default: return rot_t'($urandom());
        endcase
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(6))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return coord_t'(1);
            4: return coord_t'(-1);
            5: return coord_t'(32'sd65536);
            default: return coord_t'($urandom());
        endcase
    endfunction

    // Queue one random vertex of the given flavor.
    task automatic add_random_vertex(vertex_mix_t mix);
        real qw, qx, qy, qz, nrm, tx, ty, tz;
        case (mix)
            MIX_RAW: begin
                add_vertex(rot_t'($urandom()), rot_t'($urandom()), rot_t'($urandom()),
                           rot_t'($urandom()), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom(), $urandom());
            end
            MIX_RIGID: begin
                // Normalize a random quaternion and build d = t*r/2 so the
                // block sees a proper rigid transform.
                qw = $itor($urandom_range(2000)) - 1000.0;
                qx = $itor($urandom_range(2000)) - 1000.0;
                qy = $itor($urandom_range(2000)) - 1000.0;
                qz = $itor($urandom_range(2000)) - 1000.0;
                nrm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
                if (nrm < 1.0) begin
                    qw  = 1000.0;
                    nrm = 1000.0;
                end
                qw = qw / nrm;  qx = qx / nrm;  qy = qy / nrm;  qz = qz / nrm;
                tx = $itor($urandom_range(2000)) - 1000.0;
                ty = $itor($urandom_range(2000)) - 1000.0;
                tz = $itor($urandom_range(2000)) - 1000.0;
                add_vertex(rot_t'($rtoi(qw * 65536.0)), rot_t'($rtoi(qx * 65536.0)),
                           rot_t'($rtoi(qy * 65536.0)), rot_t'($rtoi(qz * 65536.0)),
                           $rtoi(-0.5 * (tx * qx + ty * qy + tz * qz) * 65536.0),
                           $rtoi(0.5 * (tx * qw + ty * qz - tz * qy) * 65536.0),
                           $rtoi(0.5 * (-tx * qz + ty * qw + tz * qx) * 65536.0),
                           $rtoi(0.5 * (tx * qy - ty * qx + tz * qw) * 65536.0),
                           $urandom_range(1 << 27) - (1 << 26),
                           $urandom_range(1 << 27) - (1 << 26),
                           $urandom_range(1 << 27) - (1 << 26));
            end
            MIX_EDGE: begin
                add_vertex(pick_rot(), pick_rot(), pick_rot(), pick_rot(),
                           pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                           pick_coord(), pick_coord(), pick_coord());
            end
            default: begin
                add_vertex(rot_t'($urandom_range(140000) - 70000),
                           rot_t'($urandom_range(140000) - 70000),
                           rot_t'($urandom_range(140000) - 70000),
                           rot_t'($urandom_range(140000) - 70000),
                           $urandom_range(1 << 21) - (1 << 20),
                           $urandom_range(1 << 21) - (1 << 20),
                           $urandom_range(1 << 21) - (1 << 20),
                           $urandom_range(1 << 21) - (1 << 20),
                           $urandom_range(1 << 21) - (1 << 20),
                           $urandom_range(1 << 21) - (1 << 20),
                           $urandom_range(1 << 21) - (1 << 20));
            end
        endcase
    endtask

    // Weight the traffic toward rigid transforms, keep the rest as noise.
    task automatic add_random_batch(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                add_random_vertex(MIX_RIGID);
            end else if (pick < 65) begin
                add_random_vertex(MIX_RAW);
            end else if (pick < 85) begin
                add_random_vertex(MIX_EDGE);
            end else begin
                add_random_vertex(MIX_SMALL);
            end
        end
    endtask

    // Hold off new input until the pipe is empty and every result is back.
    task automatic wait_drained();
        while (pending_vertices.size() > 0 || s_axis_tvalid ||
               expected_points.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed vertices, then four random traffic phases
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // All zero, then identity rotation on plain and extreme points.
        add_vertex('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        add_vertex(ROT_ONE, '0, '0, '0, '0, '0, '0, '0,
                   32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
        add_vertex(ROT_ONE, '0, '0, '0, '0, '0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX);
        add_vertex(ROT_ONE, '0, '0, '0, '0, '0, '0, '0, COORD_MIN, COORD_MIN, COORD_MIN);
        // Quarter turn about z, and a half-scale rotation left unnormalized.
        add_vertex(rot_t'(46341), '0, '0, rot_t'(46341), '0, '0, '0, '0,
                   32'sh0001_0000, 32'sh0000_8000, '0);
        add_vertex(rot_t'(32768), rot_t'(32768), '0, '0, '0, '0, '0, '0,
                   32'sh0010_0000, -32'sh0020_0000, 32'sh0004_0000);
        // Rotation fields at their extremes: large gain, clip both ways.
        add_vertex(ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX, '0, '0, '0, '0,
                   COORD_MAX, COORD_MAX, COORD_MAX);
        add_vertex(ROT_MIN, ROT_MIN, ROT_MIN, ROT_MIN, '0, '0, '0, '0,
                   COORD_MIN, COORD_MIN, COORD_MIN);
        add_vertex(ROT_MIN, '0, '0, '0, '0, '0, '0, '0, COORD_MAX, COORD_MIN, '0);
        add_vertex(ROT_MAX, ROT_MIN, '0, ROT_MAX, '0, '0, '0, '0,
                   COORD_MIN, COORD_MAX, COORD_MIN);
        // Translation only, large enough to clip low and high, then all fields large.
        add_vertex(ROT_ONE, '0, '0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0);
        add_vertex(ROT_ONE, '0, '0, '0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   '0, '0, '0);
        add_vertex(ROT_ONE, ROT_ONE, ROT_ONE, ROT_ONE, COORD_MAX, COORD_MIN,
                   COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        // Exact halves in the translation sum: rounds up, and to zero from below.
        add_vertex(rot_t'(1), '0, '0, '0, '0, -32'sd16384, '0, '0, '0, '0, '0);
        add_vertex(rot_t'(1), '0, '0, '0, '0, 32'sd16384, '0, '0, '0, '0, '0);
        add_vertex(rot_t'(1), '0, '0, '0, '0, -32'sd16385, 32'sd16384, '0, '0, '0, '0);
        // Exact half in a matrix entry.
        add_vertex('0, rot_t'(128), rot_t'(128), '0, '0, '0, '0, '0,
                   32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        add_vertex(rot_t'(-1), rot_t'(-1), rot_t'(-1), rot_t'(-1), 32'sd1, -32'sd1,
                   32'sd1, -32'sd1, -32'sd1, 32'sd1, -32'sd1);
        // Alternating bit patterns on every field.
        add_vertex(rot_t'(18'h15555), rot_t'(18'h2AAAA), rot_t'(18'h15555),
                   rot_t'(18'h2AAAA), 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        add_vertex(rot_t'(18'h2AAAA), rot_t'(18'h15555), rot_t'(18'h2AAAA),
                   rot_t'(18'h15555), 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        // Phase 1: full rate on both sides.
        add_random_batch(275);
        wait_drained();

        // Phase 2: sender idles often; drain once halfway through.
        src_idle_pct  = 58;
        snk_stall_pct = 0;
        add_random_batch(140);
        wait_drained();
        add_random_batch(135);
        wait_drained();

        // Phase 3: receiver applies heavy back pressure.
        src_idle_pct  = 0;
        snk_stall_pct = 58;
        add_random_batch(275);
        wait_drained();

        // Phase 4: light idling on both sides.
        src_idle_pct  = 17;
        snk_stall_pct = 17;
        add_random_batch(275);
        wait_drained();

        // Let any stray output show up before judging.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("dual_quat_point_transform regression: pass");
        end else begin
            $display("dual_quat_point_transform regression: fail");
        end
        $finish;
    end

    // Watchdog: the slowest legal run is well under a tenth of this.
    initial begin
        #2000000;
        $display("dual_quat_point_transform regression: fail");
        $finish;
    end

endmodule
